// ===== rtl/core/cenum_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cenum_pkg
// Shared constants, codes and types of the combination enumerator core.
// ----------------------------------------------------------------------------
package cenum_pkg;

  localparam int MAX_CHOOSE = 16;
  localparam int MAX_SET    = 64;

  localparam int SLOT_W     = 6;
  localparam int SEQ_W      = 63;
  localparam int POS_W      = 4;
  localparam int SET_W      = 7;
  localparam int CHOOSE_W   = 5;
  localparam int IDX_W      = $clog2(MAX_CHOOSE);
  localparam int LIM_W      = $clog2(MAX_SET + MAX_CHOOSE + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [SET_W-1:0]    SET_SIZE_RESET     = 7'd8;
  localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RESET = 5'd3;

  typedef enum logic {
    REG_SET_SIZE     = 1'b0,
    REG_CHOOSE_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SET_W-1:0]    set_size;
    logic [CHOOSE_W-1:0] choose_count;
  } cfg_t;

  typedef struct packed {
    logic             load_first;
    logic             advance;
    logic [LIM_W-1:0] choose;
    logic [LIM_W-1:0] base;
  } cell_ctl_t;

endpackage

// ===== rtl/core/cenum_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cenum_regs
// APB configuration registers: set size and choose count.
// ----------------------------------------------------------------------------
module cenum_regs
  import cenum_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t reg_index;
  logic       write_en;

  assign reg_index = reg_index_t'(paddr[2]);
  assign write_en  = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_size     <= SET_SIZE_RESET;
      cfg.choose_count <= CHOOSE_COUNT_RESET;
    end else if (write_en) begin
      case (reg_index)
        REG_SET_SIZE:     cfg.set_size     <= pwdata[SET_W-1:0];
        REG_CHOOSE_COUNT: cfg.choose_count <= pwdata[CHOOSE_W-1:0];
        default:          cfg.set_size     <= cfg.set_size;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SET_SIZE:     prdata = APB_DATA_W'(cfg.set_size);
      REG_CHOOSE_COUNT: prdata = APB_DATA_W'(cfg.choose_count);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/cenum_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cenum_cell
// One slot of the index tuple, with its limit compare and refill from the left.
// ----------------------------------------------------------------------------
module cenum_cell
  import cenum_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [SLOT_W-1:0] left_value,
  input  logic              found_in,
  output logic              found_out,
  output logic [SLOT_W-1:0] value
);

  logic             in_use;
  logic [LIM_W-1:0] limit;
  logic             can_bump;
  logic             is_pos;
  logic             fill;

  assign in_use    = LIM_W'(idx) < ctl.choose;
  assign limit     = ctl.base + LIM_W'(idx);
  assign can_bump  = in_use && (LIM_W'(value) < limit);
  assign is_pos    = can_bump && !found_in;
  assign found_out = found_in || can_bump;

  // Slots right of the bumped one copy their left neighbor plus one each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 1'b0;
    end else if (ctl.load_first || ctl.advance) begin
      fill <= ctl.advance && in_use && !found_out;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_first) begin
      if (in_use) begin
        value <= SLOT_W'(idx);
      end
    end else if (ctl.advance) begin
      if (is_pos) begin
        value <= value + 1'b1;
      end
    end else if (fill) begin
      value <= left_value + 1'b1;
    end
  end

endmodule

// ===== rtl/core/combination_enumerator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_enumerator_core
// Lexicographic enumeration of the k-element subsets of {0..m-1}.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   request   req_valid / req_ready  restart
//   result    rsp_valid / rsp_ready  seq_number, position, index_value, last,
//                                    finished
//   config    APB psel / penable     paddr, pwdata, prdata, pready
//
// A request is accepted in ST_IDLE; in ST_EMIT the output register then sends
// one slot per cycle while the result does not stall, or a single finished
// result. The refill ripples along the cell row meanwhile.
// Reset is synchronous and needs no clearing pass. A stalled result holds the
// output register and the slot counter; a new request is taken once the last
// result of the previous one is in the output register.
// ----------------------------------------------------------------------------
module combination_enumerator_core
  import cenum_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  restart,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [SEQ_W-1:0]      seq_number,
  output logic [POS_W-1:0]      position,
  output logic [SLOT_W-1:0]     index_value,
  output logic                  last,
  output logic                  finished
);

  cfg_t             cfg;
  cell_ctl_t        ctl;
  state_t           state, state_next;
  logic             active;
  logic [SEQ_W-1:0] counter;
  logic             fin_mode;
  logic [IDX_W-1:0] p;

  logic [LIM_W-1:0]  m_eff;
  logic [LIM_W-1:0]  k_ext;
  logic              bad;
  logic              accept;
  logic              start_first;
  logic              start_adv;
  logic              go_fin;
  logic              p_last;
  logic              out_load;
  logic [SLOT_W-1:0] values [MAX_CHOOSE];
  logic              found  [MAX_CHOOSE];

  cenum_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign m_eff = (LIM_W'(cfg.set_size) > LIM_W'(MAX_SET)) ? LIM_W'(MAX_SET)
                                                          : LIM_W'(cfg.set_size);
  assign k_ext = LIM_W'(cfg.choose_count);
  assign bad   = (k_ext == '0) || (k_ext > LIM_W'(MAX_CHOOSE)) || (k_ext > m_eff);

  assign req_ready   = (state == ST_IDLE);
  assign accept      = req_valid && req_ready;
  assign start_first = accept && !bad && (restart || !active);
  assign start_adv   = accept && !bad && !(restart || !active) && found[0];
  assign go_fin      = accept && !start_first && !start_adv;

  assign ctl.load_first = start_first;
  assign ctl.advance    = start_adv;
  assign ctl.choose     = k_ext;
  assign ctl.base       = m_eff - k_ext;

  for (genvar i = 0; i < MAX_CHOOSE; i++) begin : g_cell
    logic [SLOT_W-1:0] left_value;
    logic              found_in;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_inner
      assign left_value = values[i-1];
    end

    if (i == MAX_CHOOSE - 1) begin : g_end
      assign found_in = 1'b0;
    end else begin : g_mid
      assign found_in = found[i+1];
    end

    cenum_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .left_value (left_value),
      .found_in   (found_in),
      .found_out  (found[i]),
      .value      (values[i])
    );
  end

  assign p_last = (LIM_W'(p) == k_ext - LIM_W'(1));

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          out_load = 1'b1;
          if (fin_mode || p_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      counter   <= '0;
      fin_mode  <= 1'b0;
      p         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fin_mode <= go_fin;
        p        <= '0;
        if (start_first) begin
          active  <= 1'b1;
          counter <= SEQ_W'(1);
        end else if (start_adv) begin
          counter <= counter + 1'b1;
        end else begin
          active  <= 1'b0;
          counter <= '0;
        end
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
        p         <= p + 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (fin_mode) begin
        seq_number  <= '0;
        position    <= '0;
        index_value <= '0;
        last        <= 1'b1;
        finished    <= 1'b1;
      end else begin
        seq_number  <= counter;
        position    <= POS_W'(p);
        index_value <= values[p];
        last        <= p_last;
        finished    <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/combination_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_tracker
// Watches the register port and both request and result channels of the
// combination enumerator, keeps its own copy of the subset state, works out
// the slot results of every accepted request and compares each delivered
// result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module combination_tracker
  import cenum_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  logic                  restart,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [SEQ_W-1:0]      seq_number,
  input  logic [POS_W-1:0]      position,
  input  logic [SLOT_W-1:0]     index_value,
  input  logic                  last,
  input  logic                  finished,
  output int                    bad_slots,
  output int                    slots_owed
);

  localparam logic [APB_ADDR_W-1:0] SET_SIZE_ADDR     = APB_ADDR_W'(int'(REG_SET_SIZE) * 4);
  localparam logic [APB_ADDR_W-1:0] CHOOSE_COUNT_ADDR = APB_ADDR_W'(int'(REG_CHOOSE_COUNT) * 4);

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] idx;
    logic              last;
    logic              fin;
  } slot_result_t;

  logic [SET_W-1:0]    set_size_q;
  logic [CHOOSE_W-1:0] choose_q;
  logic [SLOT_W-1:0]   slots [MAX_CHOOSE];
  logic                active;
  logic [SEQ_W-1:0]    ordinal;
  slot_result_t        owed [$];
  int                  bad = 0;

  task automatic take_request(input logic rs);
    int           m;
    int           k;
    int           i;
    int           j;
    int           pos;
    int           next;
    logic         done;
    slot_result_t r;
    m    = (int'(set_size_q) > MAX_SET) ? MAX_SET : int'(set_size_q);
    k    = int'(choose_q);
    done = 1'b0;
    if (k == 0 || k > MAX_CHOOSE || k > m) begin
      done = 1'b1;
    end else if (rs || !active) begin
      for (i = 0; i < k; i++) slots[i] = SLOT_W'(i);
      active  = 1'b1;
      ordinal = SEQ_W'(1);
    end else begin
      pos = -1;
      for (j = k - 1; j >= 0; j--) begin
        if (pos < 0 && int'(slots[j]) < m - k + j) pos = j;
      end
      if (pos < 0) begin
        done = 1'b1;
      end else begin
        next = int'(slots[pos]) + 1;
        for (i = pos; i < k; i++) begin
          slots[i] = SLOT_W'(next);
          next++;
        end
        ordinal = ordinal + SEQ_W'(1);
      end
    end
    if (done) begin
      active  = 1'b0;
      ordinal = '0;
      r       = '{seq: '0, pos: '0, idx: '0, last: 1'b1, fin: 1'b1};
      owed.push_back(r);
    end else begin
      for (i = 0; i < k; i++) begin
        r.seq  = ordinal;
        r.pos  = POS_W'(i);
        r.idx  = slots[i];
        r.last = (i == k - 1);
        r.fin  = 1'b0;
        owed.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    slot_result_t exp_r;
    if (rst) begin
      set_size_q = SET_SIZE_RESET;
      choose_q   = CHOOSE_COUNT_RESET;
      active     = 1'b0;
      ordinal    = '0;
      owed.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == SET_SIZE_ADDR) set_size_q = pwdata[SET_W-1:0];
        else if (paddr == CHOOSE_COUNT_ADDR) choose_q = pwdata[CHOOSE_W-1:0];
      end
      if (req_valid && req_ready) take_request(restart);
      if (rsp_valid && rsp_ready) begin
        if (owed.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: result with none owed: seq %0d pos %0d idx %0d last %0b fin %0b",
                     $realtime, seq_number, position, index_value, last, finished);
        end else begin
          exp_r = owed.pop_front();
          if (seq_number !== exp_r.seq || position !== exp_r.pos ||
              index_value !== exp_r.idx || last !== exp_r.last ||
              finished !== exp_r.fin) begin
            bad++;
            if (bad <= 10) begin
              $display("%0t: expected seq %0d pos %0d idx %0d last %0b fin %0b",
                       $realtime, exp_r.seq, exp_r.pos, exp_r.idx, exp_r.last, exp_r.fin);
              $display("%0t: got      seq %0d pos %0d idx %0d last %0b fin %0b",
                       $realtime, seq_number, position, index_value, last, finished);
            end
          end
        end
      end
    end
    slots_owed <= owed.size();
    bad_slots  <= bad;
  end

endmodule

// ===== sim/tb_combination_enumerator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_combination_enumerator_core
// Drives the combination enumerator with a directed opening and then random
// enumeration runs, mid-pass register changes and out-of-range settings,
// under three back-pressure profiles, and reports the verdict of the tracker.
// ----------------------------------------------------------------------------
module tb_combination_enumerator_core;
  import cenum_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  req_valid   = 1'b0;
  logic                  req_ready;
  logic                  restart     = 1'b0;
  logic                  rsp_valid;
  logic                  rsp_ready   = 1'b0;
  logic [SEQ_W-1:0]      seq_number;
  logic [POS_W-1:0]      position;
  logic [SLOT_W-1:0]     index_value;
  logic                  last;
  logic                  finished;

  int bad_slots;
  int slots_owed;
  int cycles        = 0;
  int send_idle_pct = 11;
  int recv_idle_pct = 48;
  int sent          = 0;
  int cur_m         = 8;
  int cur_k         = 3;
  int written_hi    = 0;
  bit pass_started  = 1'b0;

  combination_enumerator_core DUT (.*);

  combination_tracker tracker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("combination_enumerator_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (slots_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input int v);
    logic [APB_DATA_W-1:0] word;
    settle();
    word = $urandom();
    if (r == REG_SET_SIZE) begin
      word[SET_W-1:0] = SET_W'(v);
      cur_m = v;
    end else begin
      word[CHOOSE_W-1:0] = CHOOSE_W'(v);
      cur_k = v;
    end
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_ADDR_W'(int'(r) * 4);
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A raised choose_count must not make the block read slots that no pass
  // has written yet, so such a request is turned into a restart.
  task automatic send_request(input logic rs);
    logic rs_eff;
    bit   usable;
    int   m_eff;
    m_eff  = (cur_m > MAX_SET) ? MAX_SET : cur_m;
    usable = (cur_k >= 1 && cur_k <= MAX_CHOOSE && cur_k <= m_eff);
    rs_eff = rs | (pass_started && usable && cur_k > written_hi);
    if (usable) begin
      if ((rs_eff || !pass_started) && cur_k > written_hi) written_hi = cur_k;
      pass_started = 1'b1;
    end
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    restart   <= rs_eff;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  initial begin
    int phase;
    int phase_end;
    int pick;
    int m;
    int k;
    int i;
    int count;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 4);
    write_reg(REG_CHOOSE_COUNT, 4);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 1);
    write_reg(REG_CHOOSE_COUNT, 1);
    send_request(1'b0);
    send_request(1'b0);
    write_reg(REG_CHOOSE_COUNT, 0);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 127);
    write_reg(REG_CHOOSE_COUNT, 16);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_CHOOSE_COUNT, 17);
    send_request(1'b0);
    write_reg(REG_CHOOSE_COUNT, 31);
    send_request(1'b1);
    write_reg(REG_SET_SIZE, 0);
    write_reg(REG_CHOOSE_COUNT, 1);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 64);
    write_reg(REG_CHOOSE_COUNT, 16);
    send_request(1'b0);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 5);
    write_reg(REG_CHOOSE_COUNT, 3);
    send_request(1'b1);
    write_reg(REG_SET_SIZE, 3);
    send_request(1'b0);
    write_reg(REG_SET_SIZE, 6);
    send_request(1'b1);
    write_reg(REG_CHOOSE_COUNT, 2);
    send_request(1'b0);
    write_reg(REG_CHOOSE_COUNT, 3);
    send_request(1'b0);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 11 : 0;
      phase_end = sent + 100;
      while (sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          m = $urandom_range(7, 1);
          k = $urandom_range(m, 1);
          write_reg(REG_SET_SIZE, m);
          write_reg(REG_CHOOSE_COUNT, k);
          count = 1;
          for (i = 0; i < k; i++) count = count * (m - i) / (i + 1);
          send_request($urandom_range(1));
          repeat (count) send_request($urandom_range(99) < 3);
        end else if (pick < 78) begin
          if ($urandom_range(1)) write_reg(REG_SET_SIZE, $urandom_range(10, 1));
          else write_reg(REG_CHOOSE_COUNT, $urandom_range(6, 1));
          repeat ($urandom_range(12, 1)) send_request($urandom_range(99) < 5);
        end else if (pick < 93) begin
          write_reg(REG_SET_SIZE, $urandom_range(127));
          write_reg(REG_CHOOSE_COUNT, $urandom_range(31));
          repeat ($urandom_range(4, 1)) send_request($urandom_range(1));
        end else begin
          settle();
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (bad_slots == 0) begin
      $display("combination_enumerator_core: match");
    end else begin
      $display("combination_enumerator_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cenum_pkg.sv
rtl/core/cenum_regs.sv
rtl/core/cenum_cell.sv
rtl/core/combination_enumerator_core.sv
sim/combination_tracker.sv
sim/tb_combination_enumerator_core.sv
